@@ rtl/core/closest_point_on_triangle_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the closest point on triangle unit.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_POINT_ON_TRIANGLE_UNIT_ASSERT_SVH
`define CLOSEST_POINT_ON_TRIANGLE_UNIT_ASSERT_SVH
// A condition that must hold in the cycle after another, outside reset.
`define CPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("item channel check failed");
// A condition that must hold in the cycle after a reset edge.
`define CPT_ASSERT_RESET(lbl, cons) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("reset state check failed");
`endif

@@ rtl/core/cpt_pkg.sv @@
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared constants, types and width helpers of the closest point unit.
// ----------------------------------------------------------------------------
package cpt_pkg;

  // Multiplier operand chunk and pipeline depth.
  localparam int MUL_CHUNK = 32;
  localparam int MUL_LAT   = 4;

  // Fraction bits of the barycentric parameters; one quotient bit per step.
  localparam int Q_BITS = 32;

  // Queue between the front and back parts.
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // Queue status seen by both parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Width of the numerators and divisors for a given coordinate width.
  function automatic int div_width(int w);
    return 4 * w + 9;
  endfunction

  // Width of one queue entry: nine geometry words, four division operands, two flags.
  function automatic int pl_width(int w);
    return 9 * (w + 1) + 4 * (4 * w + 9) + 2;
  endfunction

endpackage

@@ rtl/core/cpt_mul.sv @@
// ----------------------------------------------------------------------------
// cpt_mul
// Pipelined signed multiplier built from registered chunk partial products.
// ----------------------------------------------------------------------------
module cpt_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int CW   = cpt_pkg::MUL_CHUNK;
  localparam int NA   = (AW + CW - 1) / CW;
  localparam int NB   = (BW + CW - 1) / CW;
  localparam int SUMW = (NA + NB) * CW;
  localparam int PRW  = AW + BW;

  logic [AW-1:0]      abs_a;
  logic [BW-1:0]      abs_b;
  logic [NA*CW-1:0]   ma_r;
  logic [NB*CW-1:0]   mb_r;
  logic [2:0]         neg_r;
  logic [2*CW-1:0]    pp_r [NA][NB];
  logic [SUMW-1:0]    sum_nxt;
  logic [SUMW-1:0]    sum_r;
  logic [PRW-1:0]     p_r;

  // Magnitudes of the operands.
  always_comb begin
    abs_a = a[AW-1] ? AW'(-a) : AW'(a);
    abs_b = b[BW-1] ? BW'(-b) : BW'(b);
  end

  // Sum of the shifted partial products.
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_nxt = sum_nxt + (SUMW'(pp_r[i][j]) << (CW * (i + j)));
      end
    end
  end

  // Four register stages: magnitude, partial products, sum, sign.
  always_ff @(posedge clk) begin
    if (en) begin
      ma_r     <= (NA*CW)'(abs_a);
      mb_r     <= (NB*CW)'(abs_b);
      neg_r[0] <= a[AW-1] ^ b[BW-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= ma_r[i*CW +: CW] * mb_r[j*CW +: CW];
        end
      end
      neg_r[1] <= neg_r[0];
      sum_r    <= sum_nxt;
      neg_r[2] <= neg_r[1];
      p_r      <= neg_r[2] ? PRW'(-sum_r[PRW-1:0]) : sum_r[PRW-1:0];
    end
  end

  assign p = $signed(p_r);

endmodule

@@ rtl/core/cpt_div.sv @@
// ----------------------------------------------------------------------------
// cpt_div
// Pipelined clamped fraction divider: one quotient bit per stage.
// ----------------------------------------------------------------------------
module cpt_div #(
  parameter int XW = 137
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [XW-1:0]       num,
  input  logic signed [XW-1:0]       den,
  output logic [cpt_pkg::Q_BITS:0]   q
);

  localparam int N  = cpt_pkg::Q_BITS;
  localparam int RW = XW + 1;
  localparam logic [N:0] ONE = {1'b1, {N{1'b0}}};

  logic [RW-1:0] r_r   [N+1];
  logic [RW-1:0] d_r   [N+1];
  logic [N-1:0]  q_r   [N+1];
  logic          zf_r  [N+1];
  logic          of_r  [N+1];
  logic [RW-1:0] r_nxt [N+1];
  logic [N-1:0]  q_nxt [N+1];
  logic [RW-1:0] dbl;

  // One restoring step per stage.
  always_comb begin
    dbl      = '0;
    r_nxt[0] = '0;
    q_nxt[0] = '0;
    for (int k = 1; k <= N; k++) begin
      dbl = {r_r[k-1][RW-2:0], 1'b0};
      if (dbl >= d_r[k-1]) begin
        r_nxt[k] = dbl - d_r[k-1];
        q_nxt[k] = {q_r[k-1][N-2:0], 1'b1};
      end else begin
        r_nxt[k] = dbl;
        q_nxt[k] = {q_r[k-1][N-2:0], 1'b0};
      end
    end
  end

  // Entry stage classifies the clamp, later stages iterate.
  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]  <= RW'($unsigned(num));
      d_r[0]  <= RW'($unsigned(den));
      q_r[0]  <= '0;
      zf_r[0] <= (num <= 0);
      of_r[0] <= (num >= den);
      for (int k = 1; k <= N; k++) begin
        r_r[k]  <= r_nxt[k];
        d_r[k]  <= d_r[k-1];
        q_r[k]  <= q_nxt[k];
        zf_r[k] <= zf_r[k-1];
        of_r[k] <= of_r[k-1];
      end
    end
  end

  assign q = zf_r[N] ? '0 : (of_r[N] ? ONE : {1'b0, q_r[N]});

endmodule

@@ rtl/core/cpt_queue.sv @@
// ----------------------------------------------------------------------------
// cpt_queue
// Short item queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module cpt_queue #(
  parameter int PLW = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [PLW-1:0]       wdata,
  input  logic                 pop,
  output logic [PLW-1:0]       rdata,
  output cpt_pkg::q_stat_t     stat
);

  localparam int AW = cpt_pkg::QUEUE_AW;

  logic [PLW-1:0] mem_r [cpt_pkg::QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [AW:0]    cnt_r;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (AW+1)'(cpt_pkg::QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

@@ rtl/core/cpt_front.sv @@
// ----------------------------------------------------------------------------
// cpt_front
// Front part: edges, dot products, determinant and region selection.
// ----------------------------------------------------------------------------
module cpt_front #(
  parameter int W = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [W-1:0]    va [3],
  input  logic signed [W-1:0]    vb [3],
  input  logic signed [W-1:0]    vc [3],
  input  logic signed [W-1:0]    vq [3],
  input  cpt_pkg::q_stat_t       stat,
  output logic                   push,
  output logic [cpt_pkg::pl_width(W)-1:0] wdata
);

  localparam int L   = cpt_pkg::MUL_LAT;
  localparam int DW  = W + 1;
  localparam int PW  = 2 * W + 4;
  localparam int XW  = cpt_pkg::div_width(W);
  localparam int PLW = cpt_pkg::pl_width(W);
  localparam int NF  = 2 * L + 4;
  localparam int GL  = 2 * L + 3;
  localparam int DL  = L + 2;
  localparam int OFF = 9 * DW;

  logic                 en;
  logic [NF-1:0]        vf_r;
  logic signed [DW-1:0] ga_r  [GL][3];
  logic signed [DW-1:0] ge0_r [GL][3];
  logic signed [DW-1:0] ge1_r [GL][3];
  logic signed [DW-1:0] dv_r  [3];
  logic signed [DW-1:0]   m1x [15];
  logic signed [DW-1:0]   m1y [15];
  logic signed [2*DW-1:0] m1p [15];
  logic signed [PW-1:0]   dot_nxt [5];
  logic signed [PW-1:0]   dot_r [DL][5];
  logic signed [PW-1:0]   m2x [6];
  logic signed [PW-1:0]   m2y [6];
  logic signed [2*PW-1:0] m2p [6];
  logic signed [XW-1:0]   det_r, sn_r, tn_r;
  logic signed [XW-1:0]   xa, xb, xc, xd, xe;
  logic signed [XW-1:0]   nd, ne, cebd, denom;
  logic signed [XW:0]     st;
  logic                   lt, degen;
  logic signed [XW-1:0]   num_s, den_s, num_t, den_t;
  logic                   t_sel;
  logic [PLW-1:0]         pl_nxt, pl_r;

  // Stall the whole front when the last stage cannot push.
  assign en       = !(vf_r[NF-1] && stat.full);
  assign in_ready = en;
  assign push     = vf_r[NF-1] && !stat.full;
  assign wdata    = pl_r;

  // Item valid flags through the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= '0;
    end else if (en) begin
      vf_r <= {vf_r[NF-2:0], in_valid};
    end
  end

  // Edge vectors, offset and the geometry delay line.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ga_r[0][k]  <= DW'(va[k]);
        ge0_r[0][k] <= DW'(vb[k]) - DW'(va[k]);
        ge1_r[0][k] <= DW'(vc[k]) - DW'(va[k]);
        dv_r[k]     <= DW'(va[k]) - DW'(vq[k]);
      end
      for (int i = 1; i < GL; i++) begin
        ga_r[i]  <= ga_r[i-1];
        ge0_r[i] <= ge0_r[i-1];
        ge1_r[i] <= ge1_r[i-1];
      end
    end
  end

  // Operands of the fifteen coordinate products.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m1x[k]    = ge0_r[0][k];  m1y[k]    = ge0_r[0][k];
      m1x[3+k]  = ge0_r[0][k];  m1y[3+k]  = ge1_r[0][k];
      m1x[6+k]  = ge1_r[0][k];  m1y[6+k]  = ge1_r[0][k];
      m1x[9+k]  = ge0_r[0][k];  m1y[9+k]  = dv_r[k];
      m1x[12+k] = ge1_r[0][k];  m1y[12+k] = dv_r[k];
    end
  end

  for (genvar g = 0; g < 15; g++) begin : g_mul1
    cpt_mul #(.AW(DW), .BW(DW)) u_mul (
      .clk (clk), .en (en), .a (m1x[g]), .b (m1y[g]), .p (m1p[g])
    );
  end

  // Dot products a, b, c, d, e.
  always_comb begin
    for (int j = 0; j < 5; j++) begin
      dot_nxt[j] = PW'(m1p[3*j]) + PW'(m1p[3*j+1]) + PW'(m1p[3*j+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot_r[0] <= dot_nxt;
      for (int i = 1; i < DL; i++) begin
        dot_r[i] <= dot_r[i-1];
      end
    end
  end

  // Products for det, sn and tn: ac, bb, be, cd, bd, ae.
  always_comb begin
    m2x[0] = dot_r[0][0];  m2y[0] = dot_r[0][2];
    m2x[1] = dot_r[0][1];  m2y[1] = dot_r[0][1];
    m2x[2] = dot_r[0][1];  m2y[2] = dot_r[0][4];
    m2x[3] = dot_r[0][2];  m2y[3] = dot_r[0][3];
    m2x[4] = dot_r[0][1];  m2y[4] = dot_r[0][3];
    m2x[5] = dot_r[0][0];  m2y[5] = dot_r[0][4];
  end

  for (genvar g = 0; g < 6; g++) begin : g_mul2
    cpt_mul #(.AW(PW), .BW(PW)) u_mul (
      .clk (clk), .en (en), .a (m2x[g]), .b (m2y[g]), .p (m2p[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= XW'(m2p[0]) - XW'(m2p[1]);
      sn_r  <= XW'(m2p[2]) - XW'(m2p[3]);
      tn_r  <= XW'(m2p[4]) - XW'(m2p[5]);
    end
  end

  // Region selection: pick the division operands for s and t.
  always_comb begin
    xa    = XW'(dot_r[DL-1][0]);
    xb    = XW'(dot_r[DL-1][1]);
    xc    = XW'(dot_r[DL-1][2]);
    xd    = XW'(dot_r[DL-1][3]);
    xe    = XW'(dot_r[DL-1][4]);
    nd    = -xd;
    ne    = -xe;
    cebd  = xc + xe - xb - xd;
    denom = xa - (xb <<< 1) + xc;
    st    = (XW+1)'(sn_r) + (XW+1)'(tn_r);
    lt    = (st < (XW+1)'(det_r));
    degen = (det_r == '0);

    // Default: s from -d/a, t zero.
    num_s = nd;
    den_s = xa;
    num_t = '0;
    den_t = xc;
    t_sel = 1'b0;
    if (degen) begin
      // Both parameters zero return vertex A.
      num_s = '0;
    end else if (lt) begin
      if (sn_r < 0) begin
        if (!(tn_r < 0 && xd < 0)) begin
          num_s = '0;
          num_t = ne;
        end
      end else if (!(tn_r < 0)) begin
        num_s = sn_r;
        den_s = det_r;
        num_t = tn_r;
        den_t = det_r;
      end
    end else begin
      if (sn_r < 0) begin
        if (xb + xd < xc + xe) begin
          num_s = cebd;
          den_s = denom;
          t_sel = 1'b1;
        end else begin
          num_s = '0;
          num_t = ne;
        end
      end else if (tn_r < 0) begin
        if (xb + xe < xa + xd) begin
          num_s = cebd;
          den_s = denom;
          t_sel = 1'b1;
        end
      end else begin
        num_s = cebd;
        den_s = denom;
        t_sel = 1'b1;
      end
    end
  end

  // Pack the queue entry.
  always_comb begin
    pl_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      pl_nxt[k*DW +: DW]     = ga_r[GL-1][k];
      pl_nxt[(3+k)*DW +: DW] = ge0_r[GL-1][k];
      pl_nxt[(6+k)*DW +: DW] = ge1_r[GL-1][k];
    end
    pl_nxt[OFF +: XW]        = num_s;
    pl_nxt[OFF+XW +: XW]     = den_s;
    pl_nxt[OFF+2*XW +: XW]   = num_t;
    pl_nxt[OFF+3*XW +: XW]   = den_t;
    pl_nxt[OFF+4*XW]         = t_sel;
    pl_nxt[OFF+4*XW+1]       = degen;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= pl_nxt;
    end
  end

endmodule

@@ rtl/core/cpt_back.sv @@
// ----------------------------------------------------------------------------
// cpt_back
// Back part: clamped divisions, interpolation, rounding and saturation.
// ----------------------------------------------------------------------------
module cpt_back #(
  parameter int W = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cpt_pkg::q_stat_t       stat,
  input  logic [cpt_pkg::pl_width(W)-1:0] rdata,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [W-1:0]    near [3],
  output logic                   degenerate
);

  localparam int L    = cpt_pkg::MUL_LAT;
  localparam int N    = cpt_pkg::Q_BITS;
  localparam int DW   = W + 1;
  localparam int XW   = cpt_pkg::div_width(W);
  localparam int OFF  = 9 * DW;
  localparam int SW   = N + 2;
  localparam int GB   = N + L + 1;
  localparam int NBV  = N + L + 2;
  localparam int AW2  = W + N + 5;
  localparam int RESW = AW2 - N;
  localparam logic [N:0] ONE = {1'b1, {N{1'b0}}};
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  logic                   en;
  logic [NBV-1:0]         vb_r;
  logic signed [DW-1:0]   gba_r  [GB][3];
  logic signed [DW-1:0]   gbe0_r [GB][3];
  logic signed [DW-1:0]   gbe1_r [GB][3];
  logic                   gdeg_r [GB];
  logic                   tsel_r [N+1];
  logic [N:0]             s_q, t_q, t_use;
  logic signed [SW-1:0]   s_op, t_op;
  logic signed [SW+DW-1:0] ps [3];
  logic signed [SW+DW-1:0] pt [3];
  logic signed [AW2-1:0]  acc [3];
  logic signed [RESW-1:0] res [3];
  logic signed [W-1:0]    near_nxt [3];
  logic signed [W-1:0]    near_r [3];
  logic                   deg_r;

  // Stall the back part only while a finished item waits at the output.
  assign en  = !vb_r[NBV-1] || out_ready;
  assign pop = en && !stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= '0;
    end else if (en) begin
      vb_r <= {vb_r[NBV-2:0], !stat.empty};
    end
  end

  // Geometry and flags travel beside the divisions and products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        gba_r[0][k]  <= $signed(rdata[k*DW +: DW]);
        gbe0_r[0][k] <= $signed(rdata[(3+k)*DW +: DW]);
        gbe1_r[0][k] <= $signed(rdata[(6+k)*DW +: DW]);
      end
      gdeg_r[0] <= rdata[OFF+4*XW+1];
      tsel_r[0] <= rdata[OFF+4*XW];
      for (int i = 1; i < GB; i++) begin
        gba_r[i]  <= gba_r[i-1];
        gbe0_r[i] <= gbe0_r[i-1];
        gbe1_r[i] <= gbe1_r[i-1];
        gdeg_r[i] <= gdeg_r[i-1];
      end
      for (int i = 1; i <= N; i++) begin
        tsel_r[i] <= tsel_r[i-1];
      end
    end
  end

  // Clamped fractions s and t.
  cpt_div #(.XW(XW)) u_div_s (
    .clk (clk), .en (en),
    .num ($signed(rdata[OFF +: XW])), .den ($signed(rdata[OFF+XW +: XW])),
    .q   (s_q)
  );

  cpt_div #(.XW(XW)) u_div_t (
    .clk (clk), .en (en),
    .num ($signed(rdata[OFF+2*XW +: XW])), .den ($signed(rdata[OFF+3*XW +: XW])),
    .q   (t_q)
  );

  // On the far edge t is the complement of s.
  assign t_use = tsel_r[N] ? ONE - s_q : t_q;
  assign s_op  = $signed({1'b0, s_q});
  assign t_op  = $signed({1'b0, t_use});

  for (genvar g = 0; g < 3; g++) begin : g_mul
    cpt_mul #(.AW(SW), .BW(DW)) u_mul_s (
      .clk (clk), .en (en), .a (s_op), .b (gbe0_r[N][g]), .p (ps[g])
    );
    cpt_mul #(.AW(SW), .BW(DW)) u_mul_t (
      .clk (clk), .en (en), .a (t_op), .b (gbe1_r[N][g]), .p (pt[g])
    );
  end

  // A + s*E0 + t*E1, rounded to nearest, then saturated.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = (AW2'(gba_r[GB-1][k]) <<< N) + AW2'(ps[k]) + AW2'(pt[k])
             + (AW2'(1) <<< (N - 1));
      res[k] = $signed(acc[k][AW2-1:N]);
      if (res[k] > RESW'(CMAX)) begin
        near_nxt[k] = CMAX;
      end else if (res[k] < RESW'(CMIN)) begin
        near_nxt[k] = CMIN;
      end else begin
        near_nxt[k] = res[k][W-1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      near_r <= near_nxt;
      deg_r  <= gdeg_r[GB-1];
    end
  end

  assign out_valid  = vb_r[NBV-1];
  assign near       = near_r;
  assign degenerate = deg_r;

endmodule

@@ rtl/core/closest_point_on_triangle_unit.sv @@
// ----------------------------------------------------------------------------
// closest_point_on_triangle_unit
// Nearest point on a 3D triangle to a query point, signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
// - The input channel (in_valid/in_ready) carries one item: vertices A, B, C
//   and the query point, each coordinate signed two's complement.
// - The result channel (out_valid/out_ready) returns the nearest point and a
//   degenerate flag, one result per item, in order.
// - An accepted item passes through the front pipeline (edge products,
//   determinant, region choice), is written to the queue and then passes
//   through the back (32-step dividers, products, rounding).
// - Throughput is one item per cycle while the receiver does not stall;
//   every multiplier and divider stage is pipelined and the two parts run
//   concurrently.
// - When the receiver stalls, the back part holds; the four-entry queue keeps
//   absorbing front items, and in_ready drops only once it is full.
// - A synchronous reset (rst_n low) empties the pipelines and the queue;
//   in_ready is high in the cycle after reset.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_a_z,
  input  logic signed [COORD_WIDTH-1:0] in_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_z,
  input  logic signed [COORD_WIDTH-1:0] in_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_c_z,
  input  logic signed [COORD_WIDTH-1:0] in_query_x,
  input  logic signed [COORD_WIDTH-1:0] in_query_y,
  input  logic signed [COORD_WIDTH-1:0] in_query_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_near_x,
  output logic signed [COORD_WIDTH-1:0] out_near_y,
  output logic signed [COORD_WIDTH-1:0] out_near_z,
  output logic                          out_degenerate
);

  localparam int PLW = cpt_pkg::pl_width(COORD_WIDTH);

  logic signed [COORD_WIDTH-1:0] va [3];
  logic signed [COORD_WIDTH-1:0] vb [3];
  logic signed [COORD_WIDTH-1:0] vc [3];
  logic signed [COORD_WIDTH-1:0] vq [3];
  logic signed [COORD_WIDTH-1:0] near [3];
  cpt_pkg::q_stat_t              stat;
  logic                          push, pop;
  logic [PLW-1:0]                wdata, rdata;

  // Group the coordinates by point.
  assign va = '{in_a_x, in_a_y, in_a_z};
  assign vb = '{in_b_x, in_b_y, in_b_z};
  assign vc = '{in_c_x, in_c_y, in_c_z};
  assign vq = '{in_query_x, in_query_y, in_query_z};

  cpt_front #(.W(COORD_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .va       (va),
    .vb       (vb),
    .vc       (vc),
    .vq       (vq),
    .stat     (stat),
    .push     (push),
    .wdata    (wdata)
  );

  cpt_queue #(.PLW(PLW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (wdata),
    .pop   (pop),
    .rdata (rdata),
    .stat  (stat)
  );

  cpt_back #(.W(COORD_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .rdata      (rdata),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .near       (near),
    .degenerate (out_degenerate)
  );

  assign out_near_x = near[0];
  assign out_near_y = near[1];
  assign out_near_z = near[2];

endmodule

@@ rtl/core/cpt_checker.sv @@
// ----------------------------------------------------------------------------
// cpt_checker
// Port-level checks of the closest point unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "closest_point_on_triangle_unit_assert.svh"

module cpt_checker #(
  parameter int W = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic signed [W-1:0]   out_near_x,
  input logic                  out_degenerate
);

  // A stalled result item stays on the port with x and the degenerate flag unchanged.
  `CPT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_near_x) && $stable(out_degenerate))

  // Reset empties the back pipeline.
  `CPT_ASSERT_RESET(a_rst_out_idle, !out_valid)

  // Reset empties the queue, so the front takes an item right away.
  `CPT_ASSERT_RESET(a_rst_in_ready, in_ready)

endmodule

bind closest_point_on_triangle_unit cpt_checker #(.W(COORD_WIDTH)) u_cpt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_near_x     (out_near_x),
  .out_degenerate (out_degenerate)
);

@@ sim/tb_closest_point_on_triangle_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for closest_point_on_triangle_unit
// Drives triangles and query points through the valid/ready input channel,
// predicts the nearest point with wide exact integer arithmetic, and checks
// every result in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_closest_point_on_triangle_unit;

  localparam int CW         = 32;
  localparam int ONE_FIX    = 65536;
  localparam int RAND_ITEMS = 1550;
  localparam int MAX_CYCLES = 400000;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [259:0]  wide_t;

  // One query: A, B, C and P, in x/y/z order per point.
  typedef struct {
    coord_t v [12];
  } query_item_t;

  typedef struct {
    coord_t near [3];
    logic   degen;
  } near_point_t;

  // Tracks accepted queries and compares each result with its prediction.
  class nearest_point_board;
    near_point_t pending_q [$];
    int          errors;
    int          n_items;
    int          n_results;
    int          n_degen;

    // Clamped quotient num/den as unsigned Q1.32, truncated toward zero.
    function automatic wide_t clamp_ratio(wide_t num, wide_t den);
      wide_t one_q;
      one_q = wide_t'(1) <<< 32;
      if (num <= 0) return 0;
      if (num >= den) return one_q;
      return (num <<< 32) / den;
    endfunction

    function automatic near_point_t nearest_on_triangle(query_item_t it);
      near_point_t r;
      wide_t       v0 [3];
      wide_t       e0 [3];
      wide_t       e1 [3];
      wide_t       dv [3];
      wide_t       a, b, c, d, e, det, sn, tn, den, s, t, one_q, acc, res, hi, lo;
      one_q = wide_t'(1) <<< 32;
      hi = (wide_t'(1) <<< (CW - 1)) - 1;
      lo = -(wide_t'(1) <<< (CW - 1));
      for (int k = 0; k < 3; k++) begin
        v0[k] = wide_t'(it.v[k]);
        e0[k] = wide_t'(it.v[3 + k]) - v0[k];
        e1[k] = wide_t'(it.v[6 + k]) - v0[k];
        dv[k] = v0[k] - wide_t'(it.v[9 + k]);
      end
      a = e0[0] * e0[0] + e0[1] * e0[1] + e0[2] * e0[2];
      b = e0[0] * e1[0] + e0[1] * e1[1] + e0[2] * e1[2];
      c = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
      d = e0[0] * dv[0] + e0[1] * dv[1] + e0[2] * dv[2];
      e = e1[0] * dv[0] + e1[1] * dv[1] + e1[2] * dv[2];
      det = a * c - b * b;
      sn = b * e - c * d;
      tn = b * d - a * e;
      // A flat triangle returns vertex A.
      if (det == 0) begin
        for (int k = 0; k < 3; k++) r.near[k] = it.v[k];
        r.degen = 1'b1;
        return r;
      end
      den = a - 2 * b + c;
      // Pick the region and clamp the barycentric parameters.
      if (sn + tn < det) begin
        if (sn < 0) begin
          if (tn < 0 && d < 0) begin
            s = clamp_ratio(-d, a); t = 0;
          end else begin
            s = 0; t = clamp_ratio(-e, c);
          end
        end else if (tn < 0) begin
          s = clamp_ratio(-d, a); t = 0;
        end else begin
          s = clamp_ratio(sn, det); t = clamp_ratio(tn, det);
        end
      end else begin
        if (sn < 0) begin
          if (b + d < c + e) begin
            s = clamp_ratio((c + e) - (b + d), den); t = one_q - s;
          end else begin
            s = 0; t = clamp_ratio(-e, c);
          end
        end else if (tn < 0) begin
          if (b + e < a + d) begin
            s = clamp_ratio(c + e - b - d, den); t = one_q - s;
          end else begin
            s = clamp_ratio(-d, a); t = 0;
          end
        end else begin
          s = clamp_ratio(c + e - b - d, den); t = one_q - s;
        end
      end
      // Round to nearest, ties upward, then saturate.
      for (int k = 0; k < 3; k++) begin
        acc = (v0[k] <<< 32) + s * e0[k] + t * e1[k] + (wide_t'(1) <<< 31);
        res = acc >>> 32;
        if (res > hi) res = hi;
        else if (res < lo) res = lo;
        r.near[k] = coord_t'(res);
      end
      r.degen = 1'b0;
      return r;
    endfunction

    function void note_item(query_item_t it);
      near_point_t p;
      p = nearest_on_triangle(it);
      n_items++;
      if (p.degen) n_degen++;
      pending_q.insert(pending_q.size(), p);
    endfunction

    function void check_result(near_point_t got);
      near_point_t want;
      n_results++;
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing outstanding: %0d %0d %0d deg=%0b", $time,
                 got.near[0], got.near[1], got.near[2], got.degen);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      for (int k = 0; k < 3; k++) begin
        if (got.near[k] !== want.near[k]) begin
          $display("%0t: near[%0d] expected %0d actual %0d", $time, k, want.near[k],
                   got.near[k]);
          errors++;
        end
      end
      if (got.degen !== want.degen) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, want.degen, got.degen);
        errors++;
      end
    endfunction
  endclass

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  coord_t in_f [12];
  logic   out_valid;
  logic   out_ready;
  coord_t out_near_x, out_near_y, out_near_z;
  logic   out_degenerate;
  logic   calm;
  int     cycle_cnt;

  nearest_point_board board;

  closest_point_on_triangle_unit #(.COORD_WIDTH(CW)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a_x(in_f[0]), .in_a_y(in_f[1]), .in_a_z(in_f[2]),
    .in_b_x(in_f[3]), .in_b_y(in_f[4]), .in_b_z(in_f[5]),
    .in_c_x(in_f[6]), .in_c_y(in_f[7]), .in_c_z(in_f[8]),
    .in_query_x(in_f[9]), .in_query_y(in_f[10]), .in_query_z(in_f[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_near_x(out_near_x), .out_near_y(out_near_y), .out_near_z(out_near_z),
    .out_degenerate(out_degenerate)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Cycle limit guards against a hung pipeline.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver stalls at random outside the calm stretch.
  always @(posedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 8);
  end

  // Record every accepted item and check every accepted result.
  always @(posedge clk) begin
    query_item_t it;
    near_point_t got;
    if (rst_n && in_valid && in_ready) begin
      for (int k = 0; k < 12; k++) it.v[k] = in_f[k];
      board.note_item(it);
    end
    if (rst_n && out_valid && out_ready) begin
      got.near[0] = out_near_x;
      got.near[1] = out_near_y;
      got.near[2] = out_near_z;
      got.degen = out_degenerate;
      board.check_result(got);
    end
  end

  // Present one item, idling first at random, and wait until it is taken.
  task automatic send_query(query_item_t it);
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    for (int k = 0; k < 12; k++) in_f[k] <= it.v[k];
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Build an item from whole-unit coordinates.
  function automatic query_item_t units(int ax, int ay, int az, int bx, int by, int bz,
                                        int cx, int cy, int cz, int px, int py, int pz);
    query_item_t it;
    int u [12];
    u = '{ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz};
    for (int k = 0; k < 12; k++) it.v[k] = coord_t'(u[k] * ONE_FIX);
    return it;
  endfunction

  function automatic coord_t rand_near(int base, int span);
    return coord_t'(base + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Random query: some compact triangles, mostly wider ones near the query, some flat or extreme.
  function automatic query_item_t random_query();
    query_item_t it;
    int mode, span, k;
    mode = $urandom_range(0, 9);
    span = (mode < 3) ? 16 : (1 << $urandom_range(12, 24));
    for (k = 0; k < 3; k++) begin
      it.v[k] = rand_near(int'($urandom_range(0, 1 << 20)) - (1 << 19), span);
      it.v[3 + k] = rand_near(int'(it.v[k]), span);
      it.v[6 + k] = rand_near(int'(it.v[k]), span);
      it.v[9 + k] = rand_near(int'(it.v[k]), 2 * span);
    end
    if (mode == 7) begin
      // Full-range coordinates.
      for (k = 0; k < 12; k++) it.v[k] = coord_t'($urandom);
    end else if (mode == 8) begin
      // Each coordinate of C repeats A or B, or mirrors B about A, chosen per coordinate.
      for (k = 0; k < 3; k++) begin
        case ($urandom_range(0, 2))
          0: it.v[6 + k] = it.v[k];
          1: it.v[6 + k] = it.v[3 + k];
          default: it.v[6 + k] = 2 * it.v[k] - it.v[3 + k];
        endcase
      end
    end else if (mode == 9) begin
      // Coordinates close to the ends of the range.
      for (k = 0; k < 12; k++) begin
        it.v[k] = $urandom_range(0, 1) ? coord_t'(32'h7fff_ffff - $urandom_range(0, 255))
                                       : coord_t'(32'h8000_0000 + $urandom_range(0, 255));
      end
    end
    return it;
  endfunction

  initial begin
    query_item_t it;
    board = new();
    cycle_cnt = 0;
    calm <= 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    for (int k = 0; k < 12; k++) in_f[k] <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: each region of a right triangle, flat triangles, extremes.
    send_query(units(0, 0, 0, 4, 0, 0, 0, 4, 0, 1, 1, 3));
    send_query(units(0, 0, 0, 4, 0, 0, 0, 4, 0, -1, -1, 0));
    send_query(units(0, 0, 0, 4, 0, 0, 0, 4, 0, 2, -2, 1));
    send_query(units(0, 0, 0, 4, 0, 0, 0, 4, 0, -2, 2, 0));
    send_query(units(0, 0, 0, 4, 0, 0, 0, 4, 0, 6, -1, 0));
    send_query(units(0, 0, 0, 4, 0, 0, 0, 4, 0, 5, 1, 0));
    send_query(units(0, 0, 0, 4, 0, 0, 0, 4, 0, -1, 6, 0));
    send_query(units(0, 0, 0, 4, 0, 0, 0, 4, 0, 3, 3, -2));
    send_query(units(0, 0, 0, 4, 0, 0, 0, 4, 0, 1, 5, 0));
    send_query(units(1, 2, 3, 1, 2, 3, 1, 2, 3, 7, 7, 7));
    send_query(units(0, 0, 0, 1, 1, 1, 2, 2, 2, 5, 0, 0));
    send_query(units(0, 0, 0, 3, 0, 0, 0, 3, 0, 1, 1, 0));
    for (int k = 0; k < 12; k++) it.v[k] = coord_t'(32'h8000_0000);
    send_query(it);
    for (int k = 0; k < 12; k++) it.v[k] = coord_t'(32'h7fff_ffff);
    send_query(it);
    it.v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h7fff_ffff, 32'h7fff_ffff};
    send_query(it);
    it.v = '{32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0,
             32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h0};
    send_query(it);
    it.v = '{32'h1, 32'h3, 32'h0, 32'h4, 32'h1, 32'h2, 32'h2, 32'h7, 32'h5, 32'h3,
             32'h2, 32'h9};
    send_query(it);

    // Random part with a stretch where neither side idles.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm <= (n >= 600 && n < 900);
      send_query(random_query());
    end
    in_valid <= 1'b0;
    calm <= 1'b0;

    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Covered %0d queries (%0d flat triangles), %0d results checked.",
             board.n_items, board.n_degen, board.n_results);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
